@@ hw/rtl/cmo_pkg.sv @@
`default_nettype none

package cmo_pkg;

    localparam int OFFSET_W        = 20;
    localparam int OFFSET_BITS_DEF = 20;
    localparam int QUEUE_DEPTH     = 2;

    localparam int YEAR_W = 14;
    localparam int DAYS_W = 22;
    localparam int YDAY_W = 9;
    localparam int TOT_W  = 35;

    localparam logic [YEAR_W-1:0] MAX_YEAR  = 14'd9999;
    localparam logic [TOT_W-1:0]  LIMIT_MIN = 35'd5259492000;

    // floor(x / 45) for x below 2^28, as (x * DAY_RECIP) >> 34
    localparam logic [28:0] DAY_RECIP  = 29'd381774871;
    // rough year estimate, days * 400 / 146097, as (days * YEAR_RECIP) >> 30
    localparam logic [21:0] YEAR_RECIP = 22'd2939805;
    // floor(x / 60) for x below 1440, as (x * HOUR_RECIP) >> 17
    localparam logic [11:0] HOUR_RECIP = 12'd2185;

    typedef struct packed {
        logic                cmd;
        logic [5:0]          minute_in;
        logic [4:0]          hour_in;
        logic [4:0]          day_in;
        logic [3:0]          month_in;
        logic [YEAR_W-1:0]   year_in;
        logic [OFFSET_W-1:0] offset_minutes;
    } item_t;

    typedef struct packed {
        logic [5:0]        minute_out;
        logic [4:0]        hour_out;
        logic [4:0]        day_out;
        logic [3:0]        month_out;
        logic [YEAR_W-1:0] year_out;
        logic              input_bad;
        logic              year_out_of_range;
    } result_t;

    typedef struct packed {
        logic                bad;
        logic                cmd;
        logic [5:0]          minute;
        logic [4:0]          hour;
        logic [4:0]          day;
        logic [3:0]          month;
        logic [YEAR_W-1:0]   year;
        logic [YDAY_W-1:0]   yday;
        logic [OFFSET_W-1:0] offset;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_MUL,
        ST_OFF,
        ST_RANGE,
        ST_DAYS,
        ST_REM,
        ST_YEST,
        ST_DBY,
        ST_YADJ,
        ST_MON
    } back_state_t;

    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd1311;
        return p[22:15];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [11:0] y4;
        logic [11:0] y16;
        logic [7:0]  q100;
        logic [7:0]  q400;
        y4   = y[13:2];
        y16  = {2'b00, y[13:4]};
        q100 = div25(y4);
        q400 = div25(y16);
        return ((y[1:0] == 2'd0) && (y4 != 12'(q100) * 12'd25)) ||
               ((y[3:0] == 4'd0) && (y16 == 12'(q400) * 12'd25));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [YDAY_W-1:0] cum_days(input logic [3:0] m);
        logic [YDAY_W-1:0] c;
        unique case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // days from 1/1/0 to 1/1/y, valid for y up to MAX_YEAR
    function automatic logic [DAYS_W-1:0] days_before_year(input logic [YEAR_W-1:0] y);
        logic [14:0] s3;
        logic [14:0] s99;
        logic [14:0] s399;
        logic [22:0] acc;
        s3   = 15'(y) + 15'd3;
        s99  = 15'(y) + 15'd99;
        s399 = 15'(y) + 15'd399;
        acc  = 23'(y) * 23'd365 + 23'(s3[14:2])
             - 23'(div25(s99[13:2]))
             + 23'(div25({1'b0, s399[14:4]}));
        return acc[DAYS_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cmo_front.sv @@
`default_nettype none

module cmo_front
    import cmo_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       q_push,
    input  wire logic  q_full,
    output job_t       q_data
);

    localparam int EFF_BITS = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
    localparam logic [OFFSET_W-1:0] OFF_MASK = OFFSET_W'((64'd1 << EFF_BITS) - 64'd1);

    logic       leap;
    logic [4:0] mlen;

    assign leap   = is_leap(item.year_in);
    assign mlen   = month_len(item.month_in, leap);
    assign full   = q_full;
    assign q_push = push;

    always_comb
    begin
        q_data.bad    = (item.year_in > MAX_YEAR) || (item.month_in == 4'd0) ||
                        (item.month_in > 4'd12) || (item.day_in == 5'd0) ||
                        (item.day_in > mlen) || (item.hour_in > 5'd23) ||
                        (item.minute_in > 6'd59);
        q_data.cmd    = item.cmd;
        q_data.minute = item.minute_in;
        q_data.hour   = item.hour_in;
        q_data.day    = item.day_in;
        q_data.month  = item.month_in;
        q_data.year   = item.year_in;
        q_data.yday   = cum_days(item.month_in)
                      + YDAY_W'(leap && (item.month_in > 4'd2))
                      + YDAY_W'(item.day_in) - 9'd1;
        q_data.offset = item.offset_minutes & OFF_MASK;
    end

endmodule

`default_nettype wire

@@ hw/rtl/cmo_queue.sv @@
`default_nettype none

module cmo_queue
    import cmo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    output logic      full,
    input  wire job_t wdata,
    input  wire logic rd,
    output logic      empty,
    output job_t      rdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cmo_back.sv @@
`default_nettype none

module cmo_back
    import cmo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    output logic      q_pop,
    input  wire job_t q_data,
    output logic      empty,
    input  wire logic pop,
    output result_t   result
);

    back_state_t         state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;
    logic                cmd_reg, cmd_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [YEAR_W-1:0]   y_reg, y_next;
    logic [YDAY_W-1:0]   yday_reg, yday_next;
    logic [4:0]          hour_reg, hour_next;
    logic [5:0]          minute_reg, minute_next;
    logic [DAYS_W-1:0]   days_reg, days_next;
    logic [TOT_W-1:0]    tot_reg, tot_next;
    logic [56:0]         prod_reg, prod_next;
    logic [43:0]         yprod_reg, yprod_next;
    logic [10:0]         rem_reg, rem_next;
    logic [22:0]         hprod_reg, hprod_next;
    logic [DAYS_W-1:0]   dby_reg, dby_next;
    logic [YDAY_W-1:0]   d_reg, d_next;
    logic [3:0]          m_reg, m_next;

    logic              leap_y;
    logic [4:0]        mlen;
    logic [DAYS_W-1:0] dby_w;
    logic [DAYS_W-1:0] next_dby;
    logic [YEAR_W-1:0] y_est;

    assign leap_y   = is_leap(y_reg);
    assign mlen     = month_len(m_reg, leap_y);
    assign dby_w    = days_before_year(y_reg);
    assign next_dby = dby_reg + 22'd365 + DAYS_W'(leap_y);
    assign y_est    = yprod_reg[43:30];
    assign empty    = !out_valid_reg;
    assign result   = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        cmd_next       = cmd_reg;
        off_next       = off_reg;
        y_next         = y_reg;
        yday_next      = yday_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        days_next      = days_reg;
        tot_next       = tot_reg;
        prod_next      = prod_reg;
        yprod_next     = yprod_reg;
        rem_next       = rem_reg;
        hprod_next     = hprod_reg;
        dby_next       = dby_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        q_pop          = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_data.cmd;
                    off_next    = q_data.offset;
                    y_next      = q_data.year;
                    yday_next   = q_data.yday;
                    hour_next   = q_data.hour;
                    minute_next = q_data.minute;
                    if (q_data.bad)
                    begin
                        res_next.minute_out        = q_data.minute;
                        res_next.hour_out          = q_data.hour;
                        res_next.day_out           = q_data.day;
                        res_next.month_out         = q_data.month;
                        res_next.year_out          = q_data.year;
                        res_next.input_bad         = 1'b1;
                        res_next.year_out_of_range = 1'b0;
                        out_valid_next             = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE:
            begin
                days_next  = dby_w + DAYS_W'(yday_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                tot_next   = TOT_W'(days_reg) * TOT_W'(1440) +
                             TOT_W'(hour_reg) * TOT_W'(60) + TOT_W'(minute_reg);
                state_next = ST_OFF;
            end
            ST_OFF:
            begin
                tot_next   = cmd_reg ? tot_reg - TOT_W'(off_reg) : tot_reg + TOT_W'(off_reg);
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                if (tot_reg[TOT_W-1])
                begin
                    res_next.minute_out        = 6'd0;
                    res_next.hour_out          = 5'd0;
                    res_next.day_out           = 5'd1;
                    res_next.month_out         = 4'd1;
                    res_next.year_out          = '0;
                    res_next.input_bad         = 1'b0;
                    res_next.year_out_of_range = 1'b1;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
                else if (tot_reg >= LIMIT_MIN)
                begin
                    res_next.minute_out        = 6'd59;
                    res_next.hour_out          = 5'd23;
                    res_next.day_out           = 5'd31;
                    res_next.month_out         = 4'd12;
                    res_next.year_out          = MAX_YEAR;
                    res_next.input_bad         = 1'b0;
                    res_next.year_out_of_range = 1'b1;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
                else
                begin
                    prod_next  = 57'(tot_reg[32:5]) * 57'(DAY_RECIP);
                    state_next = ST_DAYS;
                end
            end
            ST_DAYS:
            begin
                days_next  = prod_reg[55:34];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                rem_next   = 11'(tot_reg[32:0] - 33'(days_reg) * 33'd1440);
                yprod_next = 44'(days_reg) * 44'(YEAR_RECIP);
                state_next = ST_YEST;
            end
            ST_YEST:
            begin
                y_next     = (y_est > MAX_YEAR) ? MAX_YEAR : y_est;
                hprod_next = 23'(rem_reg) * 23'(HOUR_RECIP);
                state_next = ST_DBY;
            end
            ST_DBY:
            begin
                dby_next   = dby_w;
                hour_next  = hprod_reg[21:17];
                state_next = ST_YADJ;
            end
            ST_YADJ:
            begin
                if (dby_reg > days_reg)
                begin
                    y_next     = y_reg - 1'b1;
                    state_next = ST_DBY;
                end
                else if ((y_reg < MAX_YEAR) && (next_dby <= days_reg))
                begin
                    y_next     = y_reg + 1'b1;
                    state_next = ST_DBY;
                end
                else
                begin
                    d_next      = YDAY_W'(days_reg - dby_reg);
                    m_next      = 4'd1;
                    minute_next = 6'(rem_reg - 11'(hour_reg) * 11'd60);
                    state_next  = ST_MON;
                end
            end
            ST_MON:
            begin
                if ((m_reg < 4'd12) && (d_reg >= YDAY_W'(mlen)))
                begin
                    d_next = d_reg - YDAY_W'(mlen);
                    m_next = m_reg + 1'b1;
                end
                else
                begin
                    res_next.minute_out        = minute_reg;
                    res_next.hour_out          = hour_reg;
                    res_next.day_out           = 5'(d_reg + 9'd1);
                    res_next.month_out         = m_reg;
                    res_next.year_out          = y_reg;
                    res_next.input_bad         = 1'b0;
                    res_next.year_out_of_range = 1'b0;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        cmd_reg    <= cmd_next;
        off_reg    <= off_next;
        y_reg      <= y_next;
        yday_reg   <= yday_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        days_reg   <= days_next;
        tot_reg    <= tot_next;
        prod_reg   <= prod_next;
        yprod_reg  <= yprod_next;
        rem_reg    <= rem_next;
        hprod_reg  <= hprod_next;
        dby_reg    <= dby_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
    end

    // result slot stays free while a beat is being worked on
    a_busy_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("result slot held while back end busy");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MON) |-> ((m_reg >= 4'd1) && (m_reg <= 4'd12)))
        else $error("month walk out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YADJ) |-> (y_reg <= MAX_YEAR))
        else $error("year search out of range");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.input_bad && res_reg.year_out_of_range))
        else $error("both error flags set");

endmodule

`default_nettype wire

@@ hw/rtl/calendar_minute_offset.sv @@
// channel   dir   handshake      payload
// item      in    push / full    item_t
// result    out   pop / empty    result_t
//
// a valid beat passes in the back end through a fixed run of multiply and search
// steps (BASE to YADJ), at most one extra DBY/YADJ pass of the year search, and
// up to eleven steps of the month walk; bad beats end in IDLE, saturated in RANGE
// the front end keeps taking beats into a two-deep queue while the back end works
// the back end takes the next beat only once the result slot has been popped
// reset clears the sequencer, queue pointers and result valid; no clearing pass
`default_nettype none

module calendar_minute_offset
    import cmo_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    job_t q_wdata;
    job_t q_rdata;

    cmo_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    cmo_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .rd    (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    cmo_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_rdata),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ tb/calendar_minute_offset_test.sv @@
module calendar_minute_offset_test
    import cmo_pkg::*;
;

    localparam int  RANDOM_STAMPS = 1300;
    localparam int  STALL_LIMIT   = 2000;
    localparam int  DRAIN_CYCLES  = 64;
    localparam int  TOP_YEAR      = 9999;
    localparam int  MIN_PER_DAY   = 1440;
    localparam int  MAX_OFFSET    = 20'hFFFFF;
    localparam bit  CMD_ADD       = 1'b0;
    localparam bit  CMD_SUB       = 1'b1;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    push      = 1'b0;
    logic    pop       = 1'b0;
    item_t   stamp_in  = '0;
    logic    full;
    logic    empty;
    result_t stamp_out;

    item_t   pending_stamps[$];
    result_t expected_stamps[$];

    logic    stamp_taken  = 1'b0;
    logic    result_taken = 1'b0;
    int      send_gap     = 0;
    bit      send_calm    = 1'b0;
    int      recv_left    = 0;
    int      recv_wait    = 0;
    bit      recv_calm    = 1'b0;
    int      quiet_cycles = 0;
    int      mismatch_count = 0;
    result_t want;

    calendar_minute_offset i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (stamp_in),
        .empty  (empty),
        .pop    (pop),
        .result (stamp_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit is_leap_year(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint days_in_month(longint m, longint y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // days from 1/1/0 up to 1/1/y
    function automatic longint days_to_year(longint y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic result_t shift_timestamp(item_t s);
        result_t r;
        longint  mi, hr, dy, mo, yr, off;
        longint  day_count, total, ceiling, rem, y, m, d;
        r   = '0;
        mi  = s.minute_in;
        hr  = s.hour_in;
        dy  = s.day_in;
        mo  = s.month_in;
        yr  = s.year_in;
        off = s.offset_minutes;
        if (yr > TOP_YEAR || mo < 1 || mo > 12 || dy < 1 ||
            dy > days_in_month(mo, yr) || hr > 23 || mi > 59)
        begin
            r.minute_out = s.minute_in;
            r.hour_out   = s.hour_in;
            r.day_out    = s.day_in;
            r.month_out  = s.month_in;
            r.year_out   = s.year_in;
            r.input_bad  = 1'b1;
            return r;
        end
        day_count = days_to_year(yr);
        for (m = 1; m < mo; m++)
        begin
            day_count += days_in_month(m, yr);
        end
        day_count += dy - 1;
        total = day_count * MIN_PER_DAY + hr * 60 + mi;
        total = s.cmd ? total - off : total + off;
        ceiling = days_to_year(TOP_YEAR + 1) * MIN_PER_DAY;
        if (total < 0)
        begin
            r.day_out           = 5'd1;
            r.month_out         = 4'd1;
            r.year_out_of_range = 1'b1;
            return r;
        end
        if (total >= ceiling)
        begin
            r.minute_out        = 6'd59;
            r.hour_out          = 5'd23;
            r.day_out           = 5'd31;
            r.month_out         = 4'd12;
            r.year_out          = 14'(TOP_YEAR);
            r.year_out_of_range = 1'b1;
            return r;
        end
        day_count = total / MIN_PER_DAY;
        rem       = total % MIN_PER_DAY;
        y = day_count * 400 / 146097;
        if (y > TOP_YEAR)
            y = TOP_YEAR;
        while (y > 0 && days_to_year(y) > day_count)
            y--;
        while (y < TOP_YEAR && days_to_year(y + 1) <= day_count)
            y++;
        d = day_count - days_to_year(y);
        m = 1;
        while (m < 12 && d >= days_in_month(m, y))
        begin
            d -= days_in_month(m, y);
            m++;
        end
        r.minute_out = 6'(rem % 60);
        r.hour_out   = 5'(rem / 60);
        r.day_out    = 5'(d + 1);
        r.month_out  = 4'(m);
        r.year_out   = 14'(y);
        return r;
    endfunction

    function automatic item_t make_stamp(bit c, int mi, int hr, int dy, int mo, int yr,
                                         int off);
        item_t s;
        s.cmd            = c;
        s.minute_in      = 6'(mi);
        s.hour_in        = 5'(hr);
        s.day_in         = 5'(dy);
        s.month_in       = 4'(mo);
        s.year_in        = 14'(yr);
        s.offset_minutes = 20'(off);
        return s;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    initial
    begin
        item_t s;
        int    pick;
        int    yr;
        int    mo;
        int    off;

        // range ends and saturation
        pending_stamps.push_back(make_stamp(CMD_ADD, 0, 0, 1, 1, 0, 0));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 1, 1, 0, 1));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 1, 1, 0, MAX_OFFSET));
        pending_stamps.push_back(make_stamp(CMD_ADD, 59, 23, 31, 12, 9999, 0));
        pending_stamps.push_back(make_stamp(CMD_ADD, 59, 23, 31, 12, 9999, 1));
        pending_stamps.push_back(make_stamp(CMD_ADD, 59, 23, 31, 12, 9999, MAX_OFFSET));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 1, 1, 1, MAX_OFFSET));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 1, 1, 2, MAX_OFFSET));
        pending_stamps.push_back(make_stamp(CMD_ADD, 30, 12, 15, 6, 9998, MAX_OFFSET));
        // leap rule
        pending_stamps.push_back(make_stamp(CMD_ADD, 59, 23, 28, 2, 2000, 1));
        pending_stamps.push_back(make_stamp(CMD_ADD, 0, 0, 28, 2, 1900, MIN_PER_DAY));
        pending_stamps.push_back(make_stamp(CMD_ADD, 59, 23, 28, 2, 2004, 1));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 1, 3, 0, 1));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 1, 3, 400, 1));
        pending_stamps.push_back(make_stamp(CMD_ADD, 59, 23, 31, 12, 1999, 1));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 1, 1, 2000, 1));
        // invalid timestamps
        pending_stamps.push_back(make_stamp(CMD_ADD, 0, 0, 29, 2, 1900, 5));
        pending_stamps.push_back(make_stamp(CMD_SUB, 0, 0, 30, 2, 2000, 5));
        pending_stamps.push_back(make_stamp(CMD_ADD, 10, 10, 31, 4, 2021, 5));
        pending_stamps.push_back(make_stamp(CMD_ADD, 10, 10, 0, 5, 2021, 5));
        pending_stamps.push_back(make_stamp(CMD_SUB, 10, 10, 5, 0, 2021, 5));
        pending_stamps.push_back(make_stamp(CMD_ADD, 10, 10, 5, 15, 2021, 5));
        pending_stamps.push_back(make_stamp(CMD_ADD, 10, 31, 5, 5, 2021, 5));
        pending_stamps.push_back(make_stamp(CMD_SUB, 63, 10, 5, 5, 2021, 5));
        pending_stamps.push_back(make_stamp(CMD_ADD, 10, 10, 5, 5, 16383, MAX_OFFSET));
        pending_stamps.push_back(make_stamp(CMD_ADD, 60, 24, 5, 13, 10000, 5));

        for (int n = 0; n < RANDOM_STAMPS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                s.cmd            = 1'($urandom_range(0, 1));
                s.minute_in      = 6'($urandom_range(0, 63));
                s.hour_in        = 5'($urandom_range(0, 31));
                s.day_in         = 5'($urandom_range(0, 31));
                s.month_in       = 4'($urandom_range(0, 15));
                s.year_in        = 14'($urandom_range(0, 16383));
                s.offset_minutes = 20'($urandom_range(0, MAX_OFFSET));
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    yr = $urandom_range(0, 2);
                else if (pick == 1)
                    yr = $urandom_range(9997, TOP_YEAR);
                else
                    yr = $urandom_range(0, TOP_YEAR);
                mo = $urandom_range(1, 12);
                pick = $urandom_range(0, 3);
                if (pick < 2)
                    off = $urandom_range(0, MAX_OFFSET);
                else if (pick == 2)
                    off = $urandom_range(0, 2000);
                else
                    off = $urandom_range(0, 100000);
                s = make_stamp(1'($urandom_range(0, 1)), $urandom_range(0, 59),
                               $urandom_range(0, 23),
                               $urandom_range(1, int'(days_in_month(mo, yr))),
                               mo, yr, off);
            end
            pending_stamps.push_back(s);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_stamps.size() > 0 || push || expected_stamps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // input beats
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || stamp_taken)
            begin
                if (send_gap > 0)
                begin
                    push     <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_stamps.size() > 0)
                begin
                    stamp_in <= pending_stamps.pop_front();
                    push     <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        send_calm = !send_calm;
                    send_gap <= send_calm ? 0 : $urandom_range(0, 16);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result beats
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pop)
            begin
                if (result_taken)
                begin
                    if ($urandom_range(0, 49) == 0)
                        recv_calm = !recv_calm;
                    recv_wait = recv_calm ? 0 : $urandom_range(0, 16);
                    if (recv_wait > 0)
                    begin
                        pop       <= 1'b0;
                        recv_left <= recv_wait - 1;
                    end
                end
            end
            else if (recv_left == 0)
            begin
                pop <= 1'b1;
            end
            else
            begin
                recv_left <= recv_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_stamps.size() == 0)
                begin
                    $error("result beat with no timestamp pending");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_stamps.pop_front();
                    check_field("minute_out", want.minute_out, stamp_out.minute_out);
                    check_field("hour_out", want.hour_out, stamp_out.hour_out);
                    check_field("day_out", want.day_out, stamp_out.day_out);
                    check_field("month_out", want.month_out, stamp_out.month_out);
                    check_field("year_out", want.year_out, stamp_out.year_out);
                    check_field("input_bad", want.input_bad, stamp_out.input_bad);
                    check_field("year_out_of_range", want.year_out_of_range,
                                stamp_out.year_out_of_range);
                end
            end
            if (push && !full)
                expected_stamps.push_back(shift_timestamp(stamp_in));
        end
        stamp_taken  <= push && !full;
        result_taken <= pop && !empty;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
